/* sv/c3k_pkg.sv */
package c3k_pkg;

  // configuration register map
  typedef enum logic [1:0] {
    REG_ROWS = 2'd0,
    REG_COLS = 2'd1,
    REG_LAST = 2'd2
  } cfg_reg_t;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 12;
  localparam int ROW_W     = 12;   // row counter, holds rows plus halo
  localparam int POS_W     = 11;   // reported row / column
  localparam int SUM_W     = 12;   // reported kernel sum

  localparam logic [CFG_W-1:0] ROWS_RST = 12'd2048;
  localparam logic [CFG_W-1:0] COLS_RST = 12'd2048;
  localparam logic             LAST_RST = 1'b1;
  localparam logic [CFG_W-1:0] ROWS_MAX = 12'd2048;
  localparam logic [ROW_W-1:0] HALO_ROWS = 12'd2;

endpackage

/* sv/c3k_ifs.sv */
interface c3k_in_if #(parameter int PIXEL_BITS = 8) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel;

  modport source(output valid, output pixel, input ready);
  modport sink(input valid, input pixel, output ready);
endinterface

interface c3k_out_if import c3k_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] conv_sum;
  logic [POS_W-1:0]        out_row;
  logic [POS_W-1:0]        out_col;
  logic                    frame_end;

  modport source(output valid, output conv_sum, output out_row, output out_col,
                 output frame_end, input ready);
  modport sink(input valid, input conv_sum, input out_row, input out_col,
               input frame_end, output ready);
endinterface

/* sv/c3k_line_mem.sv */
// Two-row line store: one entry per column, {row-2 pixel, row-1 pixel}.
module c3k_line_mem #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/c3k_col_cell.sv */
// One window column: top, middle, bottom pixel. Shifts to the left neighbor.
module c3k_col_cell #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                       clk,
  input  logic                       shift_en,
  input  logic [2:0][PIXEL_BITS-1:0] col_in,
  output logic [2:0][PIXEL_BITS-1:0] col_out,
  output logic [PIXEL_BITS+1:0]      col_sum,
  output logic [PIXEL_BITS-1:0]      mid
);

  logic [2:0][PIXEL_BITS-1:0] col_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      col_r <= col_in;
    end
  end

  assign col_out = col_r;
  assign mid     = col_r[1];
  assign col_sum = (PIXEL_BITS+2)'(col_r[0]) + (PIXEL_BITS+2)'(col_r[1])
                 + (PIXEL_BITS+2)'(col_r[2]);

endmodule

/* sv/conv3x3_fixed_kernel_stream_unit.sv */
// 3x3 Laplacian-style convolution (-1 around, +4 center) over a raster pixel
// stream, valid window positions only.
// in_chan  : one pixel per beat, raster order, valid/ready.
// out_chan : one beat per complete window: signed sum, top-left row/col of the
//            window, frame_end on the frame's last result.
// cfg_*    : write port; 0 rows_in_part, 1 cols_in_use, 2 last_part
//            (0 adds two halo rows). Any write to these restarts the frame.
//            Write only while the pipe is empty.
// Throughput: one pixel per clock unless out_chan stalls; line store is read
// once and written once per pixel on separate ports, the window is a chain of
// three column cells. Pipeline: line store read at the accept edge, then the
// window shift, then the output register; a stall can hold each step.
// Reset: counters at frame start, config to 2048 rows / 2048 cols / last
// part. Line store is not cleared; rows are written before they are read.
// Stall: out_chan holds its beat; the two internal stages fill, then
// in_chan.ready drops. ready recovers in the cycle the receiver takes a beat.
module conv3x3_fixed_kernel_stream_unit
  import c3k_pkg::*;
#(
  parameter int MAX_COLS   = 2048,
  parameter int PIXEL_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  c3k_in_if.sink               in_chan,
  c3k_out_if.source            out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int CW    = $clog2(MAX_COLS);       // column index
  localparam int CNT_W = $clog2(MAX_COLS + 1);   // column count
  localparam int ACC_W = PIXEL_BITS + 5;         // internal kernel sum

  // ---------------- configuration ----------------
  logic [CFG_W-1:0] rows_cfg_r, cols_cfg_r;
  logic             last_cfg_r;
  logic             cfg_hit;

  always_comb begin
    case (cfg_reg_t'(cfg_index))
      REG_ROWS, REG_COLS, REG_LAST: cfg_hit = cfg_we;
      default:                      cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= ROWS_RST;
      cols_cfg_r <= COLS_RST;
      last_cfg_r <= LAST_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROWS: rows_cfg_r <= cfg_wdata;
        REG_COLS: cols_cfg_r <= cfg_wdata;
        REG_LAST: last_cfg_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // clamped frame geometry
  logic [CNT_W-1:0] cols_eff;
  logic [ROW_W-1:0] rows_eff;

  always_comb begin
    if (cols_cfg_r < CFG_W'(3)) begin
      cols_eff = CNT_W'(3);
    end else if (32'(cols_cfg_r) > 32'(MAX_COLS)) begin
      cols_eff = CNT_W'(MAX_COLS);
    end else begin
      cols_eff = CNT_W'(cols_cfg_r);
    end
  end

  always_comb begin
    if (rows_cfg_r == '0) begin
      rows_eff = ROW_W'(1);
    end else if (rows_cfg_r > ROWS_MAX) begin
      rows_eff = ROWS_MAX;
    end else begin
      rows_eff = rows_cfg_r;
    end
    if (!last_cfg_r) begin
      rows_eff = rows_eff + HALO_ROWS;
    end
  end

  // ---------------- handshakes ----------------
  logic s1_v_r, s2_v_r, out_v_r;
  logic in_fire, adv1, adv2;

  assign adv2          = s2_v_r && (!out_v_r || out_chan.ready);
  assign adv1          = s1_v_r && (!s2_v_r || adv2);
  assign in_chan.ready = !s1_v_r || adv1;
  assign in_fire       = in_chan.valid && in_chan.ready;

  // ---------------- position counters ----------------
  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             last_col, last_row, emit;

  assign last_col = (CNT_W'(col_r) + CNT_W'(1)) >= cols_eff;
  assign last_row = (row_r + ROW_W'(1)) >= rows_eff;
  assign emit     = (row_r >= ROW_W'(2)) && (col_r >= CW'(2));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_fire) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------- stage 1: line store read ----------------
  logic [PIXEL_BITS-1:0] s1_px_r;
  logic [CW-1:0]         s1_col_idx_r;
  logic                  s1_emit_r, s1_end_r;
  logic [POS_W-1:0]      s1_row_r, s1_col_r;
  logic [2*PIXEL_BITS-1:0] ls_rd;
  logic [PIXEL_BITS-1:0] above, above2;

  c3k_line_mem #(
    .DEPTH(MAX_COLS),
    .WIDTH(2 * PIXEL_BITS)
  ) u_line_mem (
    .clk    (clk),
    .rd_en  (in_fire),
    .rd_addr(col_r),
    .rd_data(ls_rd),
    .wr_en  (adv1),
    .wr_addr(s1_col_idx_r),
    .wr_data({above, s1_px_r})
  );

  assign above  = ls_rd[PIXEL_BITS-1:0];
  assign above2 = ls_rd[2*PIXEL_BITS-1:PIXEL_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_v_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_px_r      <= in_chan.pixel;
      s1_col_idx_r <= col_r;
      s1_emit_r    <= emit;
      s1_end_r     <= last_col && last_row;
      s1_row_r     <= POS_W'(row_r - ROW_W'(2));
      s1_col_r     <= POS_W'(col_r - CW'(2));
    end
  end

  // ---------------- stage 2: window cell chain ----------------
  // cells[2] takes the new column, cells[0] is the left edge of the window
  logic [2:0][2:0][PIXEL_BITS-1:0] cell_col;
  logic [2:0][PIXEL_BITS+1:0]      cell_sum;
  logic [2:0][PIXEL_BITS-1:0]      cell_mid;
  logic [2:0][PIXEL_BITS-1:0]      new_col;

  assign new_col = {s1_px_r, above, above2};   // [2] bottom, [1] mid, [0] top

  for (genvar g = 0; g < 3; g++) begin : g_cell
    c3k_col_cell #(
      .PIXEL_BITS(PIXEL_BITS)
    ) u_cell (
      .clk     (clk),
      .shift_en(adv1),
      .col_in  ((g == 2) ? new_col : cell_col[(g + 1) % 3]),
      .col_out (cell_col[g]),
      .col_sum (cell_sum[g]),
      .mid     (cell_mid[g])
    );
  end

  logic             s2_end_r;
  logic [POS_W-1:0] s2_row_r, s2_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv1) begin
      s2_v_r <= s1_emit_r;          // non-emitting pixels only shift the window
    end else if (adv2) begin
      s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s2_end_r <= s1_end_r;
      s2_row_r <= s1_row_r;
      s2_col_r <= s1_col_r;
    end
  end

  // 4*center - neighbors = 5*center - all nine
  logic signed [ACC_W-1:0] ctr_s, k_sum;

  assign ctr_s = $signed(ACC_W'(cell_mid[1]));
  assign k_sum = (ctr_s <<< 2) + ctr_s
               - $signed(ACC_W'(cell_sum[0]))
               - $signed(ACC_W'(cell_sum[1]))
               - $signed(ACC_W'(cell_sum[2]));

  // ---------------- output register ----------------
  logic signed [SUM_W-1:0] out_sum_r;
  logic [POS_W-1:0]        out_row_r, out_col_r;
  logic                    out_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv2) begin
      out_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      out_sum_r <= SUM_W'(k_sum);
      out_row_r <= s2_row_r;
      out_col_r <= s2_col_r;
      out_end_r <= s2_end_r;
    end
  end

  assign out_chan.valid     = out_v_r;
  assign out_chan.conv_sum  = out_sum_r;
  assign out_chan.out_row   = out_row_r;
  assign out_chan.out_col   = out_col_r;
  assign out_chan.frame_end = out_end_r;

endmodule
